[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a holds -> b holds in the same cycle
`define CHK_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed: implication");

// a holds -> b holds in the next cycle
`define CHK_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed: next-cycle implication");

`else

`define CHK_IMPLY(label, clk, rst_n, a, b)
`define CHK_NEXT(label, clk, rst_n, a, b)

`endif

`endif

[hw/rtl/vlb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlb_pkg
// Sizes, codes and types of the VLAN learning bridge.
// ----------------------------------------------------------------------------
package vlb_pkg;

    localparam int NUM_PORTS   = 8;
    localparam int MAC_ENTRIES = 256;
    localparam int VLAN_IDS    = 4096;

    localparam int PORT_SLOTS = (NUM_PORTS < 8) ? NUM_PORTS : 8;
    localparam int VLAN_AW    = $clog2(VLAN_IDS);
    localparam int MAC_AW     = $clog2(MAC_ENTRIES);

    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] MODE_FWD      = 3'd0;
    localparam logic [2:0] MODE_LEARN    = 3'd1;
    localparam logic [2:0] MODE_ADD_PORT = 3'd2;
    localparam logic [2:0] MODE_DEL_PORT = 3'd3;
    localparam logic [2:0] MODE_SET_MODE = 3'd4;
    localparam logic [2:0] MODE_ADD_MEMB = 3'd5;
    localparam logic [2:0] MODE_SET_UP   = 3'd6;

    typedef logic [PORT_SLOTS-1:0] port_vec_t;

    typedef struct packed {
        logic [11:0] vlan;
        logic [2:0]  port;
        logic [47:0] mac;
    } mac_entry_t;

endpackage

[hw/rtl/vlan_learning_bridge_forwarder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlan_learning_bridge_forwarder
// VLAN-aware learning bridge: port table, VLAN membership, MAC table.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one command beat: forward, learn or
// a set-up operation. Output channel (out_valid/out_stall) gives result beats;
// last marks the final beat of a command. One command is in flight at a time;
// in_stall stays high from acceptance until the last result beat is taken.
// Work done per command before its first result beat:
//   forward   MAC table scanned, stopping early on a hit; each further beat
//             passes through the emit state after the previous one is taken
//   learn     one MAC entry compared per cycle until a hit or the table end
//   add/remove port, set mode: membership sweep, one VLAN row a cycle
//   add vlan member: one-row read-modify-write; set state: done at decode
// The MAC scan (one shared comparator, one entry per cycle) and the membership
// read-modify-write sweep (one row per cycle) set how long these commands take.
// Reset: ports absent, MAC entries invalid, then a clearing pass over all
// 4096 membership rows while in_stall is held high.
// A stalled output beat holds; the block waits without losing anything.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vlan_learning_bridge_forwarder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [2:0]  port,
    input  logic [11:0] vlan,
    input  logic [47:0] mac,
    input  logic        trunk,
    input  logic        up,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  out_port,
    output logic [11:0] tag_vlan,
    output logic        dropped,
    output logic        flooded,
    output logic        status,
    output logic        last
);

    localparam logic [3:0] ST_CLR    = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DECODE = 4'd2;
    localparam logic [3:0] ST_VLRD   = 4'd3;
    localparam logic [3:0] ST_SCAN   = 4'd4;
    localparam logic [3:0] ST_SWEEP  = 4'd5;
    localparam logic [3:0] ST_BUILD  = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_WAIT   = 4'd8;

    localparam logic [vlb_pkg::MAC_AW-1:0]  MT_LAST = vlb_pkg::MAC_AW'(vlb_pkg::MAC_ENTRIES - 1);
    localparam logic [vlb_pkg::VLAN_AW-1:0] VM_LAST = vlb_pkg::VLAN_AW'(vlb_pkg::VLAN_IDS - 1);

    // control state
    logic [3:0] state_reg, state_next;
    vlb_pkg::port_vec_t pt_present_reg, pt_present_next;
    vlb_pkg::port_vec_t pt_up_reg, pt_up_next;
    vlb_pkg::port_vec_t pt_trunk_reg, pt_trunk_next;
    logic [11:0] pt_vlan_reg [vlb_pkg::PORT_SLOTS];
    logic [11:0] pt_vlan_next [vlb_pkg::PORT_SLOTS];
    logic [vlb_pkg::MAC_ENTRIES-1:0] mt_valid_reg, mt_valid_next;
    logic scan_more_reg, scan_more_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic free_found_reg, free_found_next;
    logic sw_more_reg, sw_more_next;
    logic wb_vld_reg, wb_vld_next;
    logic out_valid_reg, out_valid_next;

    // working registers
    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  port_reg, port_next;
    logic [11:0] vlan_reg, vlan_next;
    logic [47:0] mac_reg, mac_next;
    logic        trunk_reg, trunk_next;
    logic        up_reg, up_next;
    logic [11:0] v_reg, v_next;
    vlb_pkg::port_vec_t row_reg, row_next;
    vlb_pkg::port_vec_t list_reg, list_next;
    logic        flood_reg, flood_next;
    logic [vlb_pkg::MAC_AW-1:0] scan_idx_reg, scan_idx_next;
    logic [vlb_pkg::MAC_AW-1:0] cmp_idx_reg, cmp_idx_next;
    logic        cmp_valid_reg, cmp_valid_next;
    logic [vlb_pkg::MAC_AW-1:0] free_idx_reg, free_idx_next;
    logic [vlb_pkg::VLAN_AW-1:0] sw_addr_reg, sw_addr_next;
    logic [vlb_pkg::VLAN_AW-1:0] sw_end_reg, sw_end_next;
    logic [vlb_pkg::VLAN_AW-1:0] wb_addr_reg, wb_addr_next;
    vlb_pkg::port_vec_t sw_clr_reg, sw_clr_next;
    logic        sw_set_reg, sw_set_next;
    logic [vlb_pkg::VLAN_AW-1:0] sw_set_addr_reg, sw_set_addr_next;
    logic [2:0]  out_port_reg, out_port_next;
    logic [11:0] tag_vlan_reg, tag_vlan_next;
    logic        dropped_reg, dropped_next;
    logic        flooded_reg, flooded_next;
    logic        status_reg, status_next;
    logic        last_reg, last_next;

    // memories
    vlb_pkg::port_vec_t vm_mem [vlb_pkg::VLAN_IDS];
    vlb_pkg::port_vec_t vm_rdata_reg;
    logic               vm_we;
    logic [vlb_pkg::VLAN_AW-1:0] vm_raddr, vm_waddr;
    vlb_pkg::port_vec_t vm_wdata;

    vlb_pkg::mac_entry_t mt_mem [vlb_pkg::MAC_ENTRIES];
    vlb_pkg::mac_entry_t mt_rdata_reg;
    logic                mt_we;
    logic [vlb_pkg::MAC_AW-1:0] mt_waddr;
    vlb_pkg::mac_entry_t mt_wdata;

    // helpers
    vlb_pkg::port_vec_t live_vec, pbit, base_vec, rest_vec;
    logic        p_in, p_ok, p_live, p_trunk, vlan_ok, res_ok, hit, at_end, q_live;
    logic [11:0] p_vlan, res_v;
    logic [2:0]  low_q, ent_q;

    logic        ld;
    logic [2:0]  ld_port;
    logic [11:0] ld_tag;
    logic        ld_drop, ld_flood, ld_status, ld_last;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_port  = out_port_reg;
    assign tag_vlan  = tag_vlan_reg;
    assign dropped   = dropped_reg;
    assign flooded   = flooded_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    assign live_vec = pt_present_reg & pt_up_reg;
    assign pbit     = vlb_pkg::port_vec_t'(1) << port_reg;
    assign p_in     = ({1'b0, port_reg} < 4'(vlb_pkg::PORT_SLOTS));
    assign p_ok     = p_in && pt_present_reg[port_reg];
    assign p_live   = p_in && live_vec[port_reg];
    assign p_trunk  = pt_trunk_reg[port_reg];
    assign p_vlan   = pt_vlan_reg[port_reg];
    assign vlan_ok  = ({1'b0, vlan_reg} < 13'(vlb_pkg::VLAN_IDS));
    // trunk ports take the tag, or their default VLAN when untagged
    assign res_v    = (p_trunk && vlan_reg != 12'd0) ? vlan_reg : p_vlan;
    assign res_ok   = ({1'b0, res_v} < 13'(vlb_pkg::VLAN_IDS));

    assign ent_q  = mt_rdata_reg.port;
    assign q_live = ({1'b0, ent_q} < 4'(vlb_pkg::PORT_SLOTS)) && live_vec[ent_q];
    assign hit    = cmp_vld_reg && cmp_valid_reg && mt_rdata_reg.vlan == v_reg
                    && mt_rdata_reg.mac == mac_reg;
    assign at_end = cmp_vld_reg && cmp_idx_reg == MT_LAST;

    assign base_vec = flood_reg ? row_reg : list_reg;

    always_comb
    begin
        low_q = 3'd0;
        for (int i = vlb_pkg::PORT_SLOTS - 1; i >= 0; i--)
        begin
            if (list_reg[i])
            begin
                low_q = 3'(i);
            end
        end
    end
    assign rest_vec = list_reg & ~(vlb_pkg::port_vec_t'(1) << low_q);

    assign vm_raddr = (state_reg == ST_DECODE) ? res_v[vlb_pkg::VLAN_AW-1:0] : sw_addr_reg;

    always_comb
    begin
        state_next       = state_reg;
        pt_present_next  = pt_present_reg;
        pt_up_next       = pt_up_reg;
        pt_trunk_next    = pt_trunk_reg;
        pt_vlan_next     = pt_vlan_reg;
        mt_valid_next    = mt_valid_reg;
        scan_more_next   = scan_more_reg;
        cmp_vld_next     = 1'b0;
        free_found_next  = free_found_reg;
        sw_more_next     = sw_more_reg;
        wb_vld_next      = 1'b0;
        out_valid_next   = out_valid_reg;
        mode_next        = mode_reg;
        port_next        = port_reg;
        vlan_next        = vlan_reg;
        mac_next         = mac_reg;
        trunk_next       = trunk_reg;
        up_next          = up_reg;
        v_next           = v_reg;
        row_next         = row_reg;
        list_next        = list_reg;
        flood_next       = flood_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_idx_next     = cmp_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        free_idx_next    = free_idx_reg;
        sw_addr_next     = sw_addr_reg;
        sw_end_next      = sw_end_reg;
        wb_addr_next     = wb_addr_reg;
        sw_clr_next      = sw_clr_reg;
        sw_set_next      = sw_set_reg;
        sw_set_addr_next = sw_set_addr_reg;
        out_port_next    = out_port_reg;
        tag_vlan_next    = tag_vlan_reg;
        dropped_next     = dropped_reg;
        flooded_next     = flooded_reg;
        status_next      = status_reg;
        last_next        = last_reg;

        vm_we     = 1'b0;
        vm_waddr  = wb_addr_reg;
        vm_wdata  = (vm_rdata_reg & ~sw_clr_reg)
                    | ((sw_set_reg && wb_addr_reg == sw_set_addr_reg) ? pbit : '0);
        mt_we     = 1'b0;
        mt_waddr  = cmp_idx_reg;
        mt_wdata  = '{vlan: v_reg, port: port_reg, mac: mac_reg};

        ld        = 1'b0;
        ld_port   = 3'd0;
        ld_tag    = 12'd0;
        ld_drop   = 1'b0;
        ld_flood  = 1'b0;
        ld_status = 1'b0;
        ld_last   = 1'b1;

        case (state_reg)
            ST_CLR:
            begin
                vm_we    = 1'b1;
                vm_waddr = sw_addr_reg;
                vm_wdata = '0;
                sw_addr_next = sw_addr_reg + vlb_pkg::VLAN_AW'(1);
                if (sw_addr_reg == VM_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode;
                    port_next  = port;
                    vlan_next  = vlan;
                    mac_next   = mac;
                    trunk_next = trunk;
                    up_next    = up;
                    state_next = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                scan_idx_next   = '0;
                scan_more_next  = 1'b1;
                free_found_next = 1'b0;
                sw_more_next    = 1'b1;
                sw_addr_next    = '0;
                sw_end_next     = VM_LAST;
                sw_clr_next     = pbit;
                sw_set_next     = 1'b0;
                sw_set_addr_next = vlan_reg[vlb_pkg::VLAN_AW-1:0];
                case (mode_reg)
                    vlb_pkg::MODE_FWD:
                    begin
                        if (!p_live)
                        begin
                            ld      = 1'b1;
                            ld_drop = 1'b1;
                        end
                        else
                        begin
                            v_next     = res_v;
                            state_next = ST_VLRD;
                        end
                    end
                    vlb_pkg::MODE_LEARN:
                    begin
                        if (mac_reg == vlb_pkg::BCAST_MAC || !p_live || !res_ok)
                        begin
                            ld        = 1'b1;
                            ld_status = 1'b1;
                        end
                        else
                        begin
                            v_next     = res_v;
                            state_next = ST_SCAN;
                        end
                    end
                    vlb_pkg::MODE_ADD_PORT:
                    begin
                        if (p_in && !pt_present_reg[port_reg])
                        begin
                            pt_present_next[port_reg] = 1'b1;
                            pt_up_next[port_reg]      = 1'b0;
                            pt_trunk_next[port_reg]   = 1'b0;
                            pt_vlan_next[port_reg]    = 12'd1;
                            sw_set_next      = 1'b1;
                            sw_set_addr_next = vlb_pkg::VLAN_AW'(1);
                            state_next       = ST_SWEEP;
                        end
                        else
                        begin
                            ld        = 1'b1;
                            ld_status = 1'b1;
                        end
                    end
                    vlb_pkg::MODE_DEL_PORT:
                    begin
                        if (p_ok)
                        begin
                            pt_present_next[port_reg] = 1'b0;
                            pt_up_next[port_reg]      = 1'b0;
                            pt_trunk_next[port_reg]   = 1'b0;
                            pt_vlan_next[port_reg]    = 12'd0;
                            state_next = ST_SWEEP;
                        end
                        else
                        begin
                            ld        = 1'b1;
                            ld_status = 1'b1;
                        end
                    end
                    vlb_pkg::MODE_SET_MODE:
                    begin
                        if (p_ok && vlan_ok)
                        begin
                            pt_trunk_next[port_reg] = trunk_reg;
                            pt_vlan_next[port_reg]  = vlan_reg;
                            sw_set_next = !trunk_reg;
                            state_next  = ST_SWEEP;
                        end
                        else
                        begin
                            ld        = 1'b1;
                            ld_status = 1'b1;
                        end
                    end
                    vlb_pkg::MODE_ADD_MEMB:
                    begin
                        if (p_ok && vlan_ok)
                        begin
                            // one-row read-modify-write
                            sw_addr_next = vlan_reg[vlb_pkg::VLAN_AW-1:0];
                            sw_end_next  = vlan_reg[vlb_pkg::VLAN_AW-1:0];
                            sw_clr_next  = '0;
                            sw_set_next  = 1'b1;
                            state_next   = ST_SWEEP;
                        end
                        else
                        begin
                            ld        = 1'b1;
                            ld_status = 1'b1;
                        end
                    end
                    vlb_pkg::MODE_SET_UP:
                    begin
                        if (p_ok)
                        begin
                            pt_up_next[port_reg] = up_reg;
                        end
                        ld        = 1'b1;
                        ld_status = !p_ok;
                    end
                    default:
                    begin
                        ld        = 1'b1;
                        ld_status = 1'b1;
                    end
                endcase
            end

            ST_VLRD:
            begin
                row_next = vm_rdata_reg;
                if (p_trunk && vlan_reg != 12'd0 && !vm_rdata_reg[port_reg])
                begin
                    ld      = 1'b1;
                    ld_drop = 1'b1;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (scan_more_reg)
                begin
                    cmp_vld_next   = 1'b1;
                    cmp_idx_next   = scan_idx_reg;
                    cmp_valid_next = mt_valid_reg[scan_idx_reg];
                    scan_idx_next  = scan_idx_reg + vlb_pkg::MAC_AW'(1);
                    scan_more_next = (scan_idx_reg != MT_LAST);
                end
                if (cmp_vld_reg && !cmp_valid_reg && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (hit || at_end)
                begin
                    scan_more_next = 1'b0;
                    cmp_vld_next   = 1'b0;
                    if (mode_reg == vlb_pkg::MODE_FWD)
                    begin
                        flood_next = !(hit && q_live);
                        list_next  = vlb_pkg::port_vec_t'(1) << ent_q;
                        state_next = ST_BUILD;
                    end
                    else if (hit)
                    begin
                        mt_we = 1'b1;
                        ld    = 1'b1;
                    end
                    else if (free_found_reg || !cmp_valid_reg)
                    begin
                        mt_we    = 1'b1;
                        mt_waddr = free_found_reg ? free_idx_reg : cmp_idx_reg;
                        ld       = 1'b1;
                    end
                    else
                    begin
                        ld        = 1'b1;
                        ld_status = 1'b1;
                    end
                end
                if (mt_we)
                begin
                    mt_valid_next[mt_waddr] = 1'b1;
                end
            end

            ST_SWEEP:
            begin
                if (sw_more_reg)
                begin
                    wb_vld_next  = 1'b1;
                    wb_addr_next = sw_addr_reg;
                    sw_more_next = (sw_addr_reg != sw_end_reg);
                    sw_addr_next = sw_addr_reg + vlb_pkg::VLAN_AW'(1);
                end
                vm_we = wb_vld_reg;
                if (wb_vld_reg && wb_addr_reg == sw_end_reg)
                begin
                    ld = 1'b1;
                end
            end

            ST_BUILD:
            begin
                list_next  = base_vec & live_vec & ~pbit;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                ld       = 1'b1;
                ld_flood = flood_reg;
                if (list_reg == '0)
                begin
                    ld_drop = 1'b1;
                end
                else
                begin
                    ld_port   = low_q;
                    ld_tag    = pt_trunk_reg[low_q] ? v_reg : 12'd0;
                    ld_last   = (rest_vec == '0);
                    list_next = rest_vec;
                end
            end

            ST_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = last_reg ? ST_IDLE : ST_EMIT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (ld)
        begin
            out_port_next  = ld_port;
            tag_vlan_next  = ld_tag;
            dropped_next   = ld_drop;
            flooded_next   = ld_flood;
            status_next    = ld_status;
            last_next      = ld_last;
            out_valid_next = 1'b1;
            state_next     = ST_WAIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            pt_present_reg <= '0;
            pt_up_reg      <= '0;
            pt_trunk_reg   <= '0;
            for (int i = 0; i < vlb_pkg::PORT_SLOTS; i++)
            begin
                pt_vlan_reg[i] <= 12'd0;
            end
            mt_valid_reg   <= '0;
            scan_more_reg  <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            sw_more_reg    <= 1'b0;
            wb_vld_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            sw_addr_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pt_present_reg <= pt_present_next;
            pt_up_reg      <= pt_up_next;
            pt_trunk_reg   <= pt_trunk_next;
            pt_vlan_reg    <= pt_vlan_next;
            mt_valid_reg   <= mt_valid_next;
            scan_more_reg  <= scan_more_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            sw_more_reg    <= sw_more_next;
            wb_vld_reg     <= wb_vld_next;
            out_valid_reg  <= out_valid_next;
            sw_addr_reg    <= sw_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        port_reg        <= port_next;
        vlan_reg        <= vlan_next;
        mac_reg         <= mac_next;
        trunk_reg       <= trunk_next;
        up_reg          <= up_next;
        v_reg           <= v_next;
        row_reg         <= row_next;
        list_reg        <= list_next;
        flood_reg       <= flood_next;
        scan_idx_reg    <= scan_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        cmp_valid_reg   <= cmp_valid_next;
        free_idx_reg    <= free_idx_next;
        sw_end_reg      <= sw_end_next;
        wb_addr_reg     <= wb_addr_next;
        sw_clr_reg      <= sw_clr_next;
        sw_set_reg      <= sw_set_next;
        sw_set_addr_reg <= sw_set_addr_next;
        out_port_reg    <= out_port_next;
        tag_vlan_reg    <= tag_vlan_next;
        dropped_reg     <= dropped_next;
        flooded_reg     <= flooded_next;
        status_reg      <= status_next;
        last_reg        <= last_next;
    end

    // VLAN membership rows
    always_ff @(posedge clk)
    begin
        if (vm_we)
        begin
            vm_mem[vm_waddr] <= vm_wdata;
        end
        vm_rdata_reg <= vm_mem[vm_raddr];
    end

    // MAC table entries; validity kept in mt_valid_reg
    always_ff @(posedge clk)
    begin
        if (mt_we)
        begin
            mt_mem[mt_waddr] <= mt_wdata;
        end
        mt_rdata_reg <= mt_mem[scan_idx_reg];
    end

    `CHK_IMPLY(a_idle_no_out, clk, rst_n, !in_stall, !out_valid)
    `CHK_IMPLY(a_drop_is_last, clk, rst_n, out_valid && dropped, last && !status)
    `CHK_IMPLY(a_status_is_last, clk, rst_n, out_valid && status, last && !dropped)
    `CHK_NEXT(a_last_frees_input, clk, rst_n, out_valid && !out_stall && last,
              !out_valid && !in_stall)

endmodule
